@@ rtl/core/soeu_pkg.sv @@
// Shared types, opcodes and widths of the sixteen-opcode execute unit.
package soeu_pkg;

    localparam int REG_COUNT_DEF  = 13;
    localparam int DATA_DEPTH_DEF = 1024;

    localparam int DATA_W  = 16;
    localparam int IDX_W   = 4;
    localparam int IP_W    = 16;
    localparam int INSTR_W = 32;
    localparam int MADDR_W = 10;
    localparam int IN_W    = INSTR_W + IP_W;
    localparam int RES_W   = 68;
    localparam int OUT_W   = 72;

    localparam logic [3:0] OP_HALT = 4'd0;
    localparam logic [3:0] OP_LDR  = 4'd1;
    localparam logic [3:0] OP_STR  = 4'd2;
    localparam logic [3:0] OP_ADD  = 4'd3;
    localparam logic [3:0] OP_SUB  = 4'd4;
    localparam logic [3:0] OP_MOV  = 4'd5;
    localparam logic [3:0] OP_CMP  = 4'd6;
    localparam logic [3:0] OP_B    = 4'd7;
    localparam logic [3:0] OP_BEQ  = 4'd8;
    localparam logic [3:0] OP_BLT  = 4'd9;
    localparam logic [3:0] OP_AND  = 4'd10;
    localparam logic [3:0] OP_ORR  = 4'd11;
    localparam logic [3:0] OP_EOR  = 4'd12;
    localparam logic [3:0] OP_MVN  = 4'd13;
    localparam logic [3:0] OP_LSL  = 4'd14;
    localparam logic [3:0] OP_LSR  = 4'd15;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] val;
    } wb_t;

    typedef struct packed {
        logic less;
        logic eq;
    } flags_t;

    typedef struct packed {
        logic                less_flag;
        logic                equal_flag;
        logic [DATA_W-1:0]   mem_value;
        logic [MADDR_W-1:0]  mem_address;
        logic                mem_written;
        logic [DATA_W-1:0]   reg_value;
        logic [IDX_W-1:0]    reg_index;
        logic                reg_written;
        logic                branch_taken;
        logic                halted;
        logic [IP_W-1:0]     next_ip;
    } res_t;

endpackage

@@ rtl/core/soeu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module soeu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/soeu_fwd.sv @@
// Register operand select with bypass from the pending and the last write-back.
module soeu_fwd import soeu_pkg::*; (
    input  logic [IDX_W-1:0]  idx,
    input  logic              in_range,
    input  logic [DATA_W-1:0] ram_val,
    input  wb_t               near_wb,
    input  wb_t               far_wb,
    output logic [DATA_W-1:0] val
);

    always_comb
    begin
        priority if (!in_range)
        begin
            val = '0;
        end
        else if (near_wb.en && near_wb.idx == idx)
        begin
            val = near_wb.val;
        end
        else if (far_wb.en && far_wb.idx == idx)
        begin
            val = far_wb.val;
        end
        else
        begin
            val = ram_val;
        end
    end

endmodule

@@ rtl/core/soeu_alu.sv @@
// Execute stage: opcode decode, arithmetic, compare, branch and result word.
module soeu_alu import soeu_pkg::*; (
    input  logic [3:0]         op,
    input  logic [IP_W-1:0]    ip,
    input  logic [DATA_W-1:0]  imm,
    input  logic [IDX_W-1:0]   r1,
    input  logic               r1_ok,
    input  logic [DATA_W-1:0]  a,
    input  logic [DATA_W-1:0]  b,
    input  logic [DATA_W-1:0]  r1_val,
    input  logic [DATA_W-1:0]  mdata,
    input  logic [MADDR_W-1:0] maddr,
    input  flags_t             flags_in,
    output flags_t             flags_next,
    output wb_t                wb,
    output res_t               res
);

    logic [IP_W-1:0]    next;
    logic               halted;
    logic               taken;
    logic               wr;
    logic               mw;
    logic [DATA_W-1:0]  wval;
    logic [DATA_W-1:0]  mval;
    logic [MADDR_W-1:0] maddr_o;
    logic               big_shift;
    logic               wr_eff;

    assign big_shift = (b[DATA_W-1:4] != '0);

    always_comb
    begin
        next       = ip + IP_W'(1);
        halted     = 1'b0;
        taken      = 1'b0;
        wr         = 1'b0;
        mw         = 1'b0;
        wval       = '0;
        mval       = '0;
        maddr_o    = '0;
        flags_next = flags_in;
        unique case (op)
            OP_HALT:
            begin
                halted = 1'b1;
                next   = ip;
            end
            OP_LDR:
            begin
                wr      = 1'b1;
                wval    = mdata;
                mval    = mdata;
                maddr_o = maddr;
            end
            OP_STR:
            begin
                mw      = 1'b1;
                mval    = r1_val;
                maddr_o = maddr;
            end
            OP_ADD:
            begin
                wr   = 1'b1;
                wval = a + b;
            end
            OP_SUB:
            begin
                wr   = 1'b1;
                wval = a - b;
            end
            OP_MOV:
            begin
                wr   = 1'b1;
                wval = b;
            end
            OP_CMP:
            begin
                flags_next.eq   = (r1_val == b);
                flags_next.less = ($signed(r1_val) < $signed(b));
            end
            OP_B:
            begin
                taken = 1'b1;
            end
            OP_BEQ:
            begin
                taken = flags_in.eq;
            end
            OP_BLT:
            begin
                taken = flags_in.less;
            end
            OP_AND:
            begin
                wr   = 1'b1;
                wval = a & b;
            end
            OP_ORR:
            begin
                wr   = 1'b1;
                wval = a | b;
            end
            OP_EOR:
            begin
                wr   = 1'b1;
                wval = a ^ b;
            end
            OP_MVN:
            begin
                wr   = 1'b1;
                wval = ~b;
            end
            OP_LSL:
            begin
                wr   = 1'b1;
                wval = big_shift ? '0 : (a << b[3:0]);
            end
            OP_LSR:
            begin
                wr   = 1'b1;
                wval = big_shift ? '0 : (a >> b[3:0]);
            end
        endcase
        if (taken)
        begin
            next = imm;
        end
    end

    assign wr_eff = wr && r1_ok;

    assign wb.en  = wr_eff;
    assign wb.idx = r1;
    assign wb.val = wval;

    assign res.next_ip      = next;
    assign res.halted       = halted;
    assign res.branch_taken = taken;
    assign res.reg_written  = wr_eff;
    assign res.reg_index    = wr_eff ? r1 : '0;
    assign res.reg_value    = wr_eff ? wval : '0;
    assign res.mem_written  = mw;
    assign res.mem_address  = maddr_o;
    assign res.mem_value    = mval;
    assign res.equal_flag   = flags_next.eq;
    assign res.less_flag    = flags_next.less;

endmodule

@@ rtl/core/sixteen_opcode_execute_unit.sv @@
// Top level of the sixteen-opcode execute unit: pipeline, memories and handshakes.
// Operand, execute and output registers; one word per cycle unless m_tready is low
// or the clearing pass runs; register reads at accept, data memory read in the
// operand stage, write-back at execute, with bypass covering back-to-back dependencies.
// Reset: after rst_n rises, s_tready stays low for DATA_DEPTH cycles while a clearing
// pass zeroes the data memory and register file; flags and pipeline valids reset at once.
module sixteen_opcode_execute_unit import soeu_pkg::*; #(
    parameter int REG_COUNT  = REG_COUNT_DEF,
    parameter int DATA_DEPTH = DATA_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // instruction_word[31:0], current_ip[47:32]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // next_ip[15:0], halted[16], branch_taken[17],
                                        // reg_written[18], reg_index[22:19],
                                        // reg_value[38:23], mem_written[39],
                                        // mem_address[49:40], mem_value[65:50],
                                        // equal_flag[66], less_flag[67], zero pad
);

    localparam int RAW     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int DAW     = $clog2(DATA_DEPTH);
    localparam int RECIP_W = 29;
    localparam int PROD_W  = 48;
    localparam int REM_W   = 33;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << 32) + 64'(DATA_DEPTH) - 64'd1) / 64'(DATA_DEPTH));

    logic               in_acc;
    logic [INSTR_W-1:0] in_instr;
    logic [IP_W-1:0]    in_ip;
    logic [PROD_W-1:0]  in_prod;

    logic               clr_busy_reg;
    logic               clr_busy_next;
    logic [DAW-1:0]     clr_cnt_reg;
    logic [DAW-1:0]     clr_cnt_next;
    logic               clr_reg_we;

    logic               a_valid_reg;
    logic               a_valid_next;
    logic [INSTR_W-1:0] a_instr_reg;
    logic [IP_W-1:0]    a_ip_reg;
    logic [DATA_W-1:0]  a_q_reg;
    logic               a_adv;

    logic [IDX_W-1:0]   a_r1;
    logic [IDX_W-1:0]   a_r2;
    logic [IDX_W-1:0]   a_rb;
    logic               a_r1_ok;
    logic               a_r2_ok;
    logic               a_rb_ok;
    logic               a_sel;
    logic [DATA_W-1:0]  a_imm;
    logic [REM_W-1:0]   a_qd;
    logic [REM_W-1:0]   a_rem;
    logic [DAW-1:0]     a_addr;
    logic [DATA_W-1:0]  a_fa;
    logic [DATA_W-1:0]  a_fb;
    logic [DATA_W-1:0]  a_fr1;

    logic [DATA_W-1:0]  rf_a_rdata;
    logic [DATA_W-1:0]  rf_b_rdata;
    logic [DATA_W-1:0]  rf_r1_rdata;
    logic               rf_we;
    logic [RAW-1:0]     rf_waddr;
    logic [DATA_W-1:0]  rf_wdata;

    logic               b_valid_reg;
    logic               b_valid_next;
    logic [3:0]         b_op_reg;
    logic [IDX_W-1:0]   b_r1_reg;
    logic               b_r1ok_reg;
    logic [IP_W-1:0]    b_ip_reg;
    logic [DATA_W-1:0]  b_imm_reg;
    logic [DATA_W-1:0]  b_a_reg;
    logic [DATA_W-1:0]  b_b_reg;
    logic [DATA_W-1:0]  b_r1v_reg;
    logic [DAW-1:0]     b_addr_reg;
    logic               b_mfwd_reg;
    logic [DATA_W-1:0]  b_mval_reg;
    logic               b_commit;
    logic [IP_W-1:0]    b_addr_ext;
    logic [DATA_W-1:0]  b_mdata;
    wb_t                b_wb;
    wb_t                b_near;
    flags_t             b_flags_next;
    res_t               b_res;

    logic [DATA_W-1:0]  dm_rdata;
    logic               dm_we;
    logic [DAW-1:0]     dm_waddr;
    logic [DATA_W-1:0]  dm_wdata;

    wb_t                w_reg;
    wb_t                w_next;
    flags_t             flags_reg;
    flags_t             flags_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    res_t               out_res_reg;

    assign in_instr = s_tdata[INSTR_W-1:0];
    assign in_ip    = s_tdata[IN_W-1:INSTR_W];
    assign in_prod  = PROD_W'(in_instr[DATA_W-1:0]) * PROD_W'(RECIP);

    assign b_commit = b_valid_reg && (!out_valid_reg || m_tready);
    assign a_adv    = a_valid_reg && (!b_valid_reg || b_commit);
    assign s_tready = !clr_busy_reg && (!a_valid_reg || a_adv);
    assign in_acc   = s_tvalid && s_tready;

    assign a_valid_next   = in_acc ? 1'b1 : (a_adv ? 1'b0 : a_valid_reg);
    assign b_valid_next   = a_adv ? 1'b1 : (b_commit ? 1'b0 : b_valid_reg);
    assign out_valid_next = b_commit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    assign clr_cnt_next  = clr_busy_reg ? clr_cnt_reg + DAW'(1) : clr_cnt_reg;
    assign clr_busy_next = clr_busy_reg && (clr_cnt_reg != DAW'(DATA_DEPTH - 1));
    assign clr_reg_we    = clr_busy_reg && ({1'b0, clr_cnt_reg} < (DAW + 1)'(REG_COUNT));

    assign w_next     = (b_commit && b_wb.en) ? b_wb : w_reg;
    assign flags_next = b_commit ? b_flags_next : flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            w_reg         <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            w_reg         <= w_next;
            flags_reg     <= flags_next;
        end
    end

    // Operand stage capture
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_instr_reg <= in_instr;
            a_ip_reg    <= in_ip;
            a_q_reg     <= in_prod[PROD_W-1:PROD_W-DATA_W];
        end
    end

    assign a_r1    = a_instr_reg[27:24];
    assign a_r2    = a_instr_reg[23:20];
    assign a_sel   = (a_instr_reg[19:16] != '0);
    assign a_rb    = a_instr_reg[3:0];
    assign a_imm   = a_instr_reg[DATA_W-1:0];
    assign a_r1_ok = ({1'b0, a_r1} < (IDX_W + 1)'(REG_COUNT));
    assign a_r2_ok = ({1'b0, a_r2} < (IDX_W + 1)'(REG_COUNT));
    assign a_rb_ok = ({1'b0, a_rb} < (IDX_W + 1)'(REG_COUNT));

    // Address modulo the data depth: reciprocal quotient, then multiply back and subtract
    assign a_qd   = REM_W'(a_q_reg) * REM_W'(DATA_DEPTH);
    assign a_rem  = REM_W'(a_imm) - a_qd;
    assign a_addr = a_rem[DAW-1:0];

    assign b_near.en  = b_valid_reg && b_wb.en;
    assign b_near.idx = b_wb.idx;
    assign b_near.val = b_wb.val;

    soeu_fwd u_fwd_a (
        .idx      (a_r2),
        .in_range (a_r2_ok),
        .ram_val  (rf_a_rdata),
        .near_wb  (b_near),
        .far_wb   (w_reg),
        .val      (a_fa)
    );

    soeu_fwd u_fwd_b (
        .idx      (a_rb),
        .in_range (a_rb_ok),
        .ram_val  (rf_b_rdata),
        .near_wb  (b_near),
        .far_wb   (w_reg),
        .val      (a_fb)
    );

    soeu_fwd u_fwd_r1 (
        .idx      (a_r1),
        .in_range (a_r1_ok),
        .ram_val  (rf_r1_rdata),
        .near_wb  (b_near),
        .far_wb   (w_reg),
        .val      (a_fr1)
    );

    // Execute stage capture
    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            b_op_reg   <= a_instr_reg[31:28];
            b_r1_reg   <= a_r1;
            b_r1ok_reg <= a_r1_ok;
            b_ip_reg   <= a_ip_reg;
            b_imm_reg  <= a_imm;
            b_a_reg    <= a_fa;
            b_b_reg    <= a_sel ? a_fb : a_imm;
            b_r1v_reg  <= a_fr1;
            b_addr_reg <= a_addr;
            b_mfwd_reg <= b_valid_reg && b_res.mem_written && (b_addr_reg == a_addr);
            b_mval_reg <= b_res.mem_value;
        end
    end

    assign b_addr_ext = IP_W'(b_addr_reg);
    assign b_mdata    = b_mfwd_reg ? b_mval_reg : dm_rdata;

    soeu_alu u_alu (
        .op         (b_op_reg),
        .ip         (b_ip_reg),
        .imm        (b_imm_reg),
        .r1         (b_r1_reg),
        .r1_ok      (b_r1ok_reg),
        .a          (b_a_reg),
        .b          (b_b_reg),
        .r1_val     (b_r1v_reg),
        .mdata      (b_mdata),
        .maddr      (b_addr_ext[MADDR_W-1:0]),
        .flags_in   (flags_reg),
        .flags_next (b_flags_next),
        .wb         (b_wb),
        .res        (b_res)
    );

    always_ff @(posedge clk)
    begin
        if (b_commit)
        begin
            out_res_reg <= b_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - RES_W){1'b0}}, out_res_reg};

    // Register file: three read copies sharing one write port
    assign rf_we    = clr_reg_we || (b_commit && b_wb.en);
    assign rf_waddr = clr_busy_reg ? clr_cnt_reg[RAW-1:0] : b_wb.idx[RAW-1:0];
    assign rf_wdata = clr_busy_reg ? '0 : b_wb.val;

    soeu_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (in_acc),
        .raddr (in_instr[20 +: RAW]),
        .rdata (rf_a_rdata)
    );

    soeu_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (in_acc),
        .raddr (in_instr[0 +: RAW]),
        .rdata (rf_b_rdata)
    );

    soeu_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_r1 (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (in_acc),
        .raddr (in_instr[24 +: RAW]),
        .rdata (rf_r1_rdata)
    );

    // Data memory
    assign dm_we    = clr_busy_reg || (b_commit && b_res.mem_written);
    assign dm_waddr = clr_busy_reg ? clr_cnt_reg : b_addr_reg;
    assign dm_wdata = clr_busy_reg ? '0 : b_res.mem_value;

    soeu_ram #(.WIDTH(DATA_W), .DEPTH(DATA_DEPTH)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (a_adv),
        .raddr (a_addr),
        .rdata (dm_rdata)
    );

endmodule

@@ rtl/core/soeu_check.sv @@
// Port-level assertions for the sixteen-opcode execute unit, bound to the top level.
module soeu_check import soeu_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    res_t r;

    assign r = m_tdata[RES_W-1:0];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r.halted |-> !r.branch_taken && !r.reg_written && !r.mem_written)
        else $error("halt word reports a branch or a write");

    a_reg_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !r.reg_written |-> r.reg_index == '0 && r.reg_value == '0)
        else $error("register fields nonzero without a register write");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(r.reg_written && r.mem_written))
        else $error("register and memory written by one word");

endmodule

bind sixteen_opcode_execute_unit soeu_check u_soeu_check (.*);
